[src/csnms_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the corner score suppression block.
package csnms_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_SCORE_BITS = 8;

   localparam int SCORE_IN_BITS = 8;
   localparam int WIDTH_BITS    = 11;
   localparam int OUT_X_BITS    = 10;
   localparam int ROW_BITS      = 12;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 11;

   localparam int MIN_WIDTH = 3;

   localparam logic [ROW_BITS-1:0]   ROW_SAT           = 12'hFFF;
   localparam logic [WIDTH_BITS-1:0] RST_IMAGE_WIDTH   = 11'd640;
   localparam logic                  RST_SUPPRESS_EN   = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_WIDTH     = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SUPPRESS_ENABLE = 1'd1;

   typedef struct packed {
      logic [SCORE_IN_BITS-1:0] corner_score;
      logic                     frame_start;
   } req_type;

   typedef struct packed {
      logic                  out_valid;
      logic [OUT_X_BITS-1:0] out_x;
      logic [ROW_BITS-1:0]   out_y;
      logic                  keep;
   } rsp_type;

   function automatic logic [ROW_BITS-1:0] row_sat_inc(input logic [ROW_BITS-1:0] r);
      row_sat_inc = (r == ROW_SAT) ? r : r + 1'b1;
   endfunction

endpackage

[src/csnms_line_buf.sv]
`timescale 1ns / 1ps
// Two row line buffers with registered read, write forwarding and clear after reset.
module csnms_line_buf
   import csnms_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int SCORE_BITS = DEF_SCORE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  logic [SCORE_BITS-1:0]         wr_upper,
   input  logic [SCORE_BITS-1:0]         wr_middle,
   output logic [SCORE_BITS-1:0]         rd_upper,
   output logic [SCORE_BITS-1:0]         rd_middle,
   output logic                          busy
);

   localparam int XB = $clog2(MAX_WIDTH);

   logic [SCORE_BITS-1:0] upper_mem  [MAX_WIDTH];
   logic [SCORE_BITS-1:0] middle_mem [MAX_WIDTH];

   logic                  clr_ff, clr_in;
   logic [XB-1:0]         clr_addr_ff, clr_addr_in;
   logic [SCORE_BITS-1:0] rd_upper_ff, rd_middle_ff;
   logic                  fwd;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == XB'(MAX_WIDTH - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign fwd = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         upper_mem[clr_addr_ff]  <= '0;
         middle_mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         upper_mem[wr_addr]  <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
      if (rd_en) begin
         rd_upper_ff  <= fwd ? wr_upper  : upper_mem[rd_addr];
         rd_middle_ff <= fwd ? wr_middle : middle_mem[rd_addr];
      end
   end

   assign rd_upper  = rd_upper_ff;
   assign rd_middle = rd_middle_ff;
   assign busy      = clr_ff;

endmodule

[src/csnms_position.sv]
`timescale 1ns / 1ps
// Column and row counters giving the raster position of each incoming beat.
module csnms_position
   import csnms_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           frame_start,
   input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
   output logic [$clog2(MAX_WIDTH)-1:0]   x,
   output logic [ROW_BITS-1:0]            y
);

   localparam int XB = $clog2(MAX_WIDTH);
   localparam int WB = $clog2(MAX_WIDTH + 1);

   logic [XB-1:0]       col_ff, col_in, col_s;
   logic [ROW_BITS-1:0] row_ff, row_in, row_s;
   logic [WB-1:0]       nxt;

   always_comb begin
      col_s = frame_start ? '0 : col_ff;
      row_s = frame_start ? '0 : row_ff;
      if (WB'(col_s) >= width) begin
         x = '0;
         y = row_sat_inc(row_s);
      end else begin
         x = col_s;
         y = row_s;
      end
      nxt = WB'(x) + 1'b1;
      if (nxt >= width) begin
         col_in = '0;
         row_in = row_sat_inc(y);
      end else begin
         col_in = XB'(nxt);
         row_in = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |-> (WB'(x) < width))
      else $error("column outside the image width");

endmodule

[src/csnms_window.sv]
`timescale 1ns / 1ps
// 3x3 score window and the keep decision for the pixel at its centre.
module csnms_window
   import csnms_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int SCORE_BITS = DEF_SCORE_BITS
) (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [$clog2(MAX_WIDTH)-1:0]   x,
   input  logic [ROW_BITS-1:0]            y,
   input  logic [SCORE_BITS-1:0]          score,
   input  logic [SCORE_BITS-1:0]          rd_upper,
   input  logic [SCORE_BITS-1:0]          rd_middle,
   input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
   input  logic                           suppress_en,
   output rsp_type                        result
);

   localparam int XB = $clog2(MAX_WIDTH);
   localparam int WB = $clog2(MAX_WIDTH + 1);

   logic [SCORE_BITS-1:0] win_ff [3][3];
   logic [SCORE_BITS-1:0] nw     [3][3];
   logic [XB-1:0]         cx;
   logic [ROW_BITS-1:0]   cy;
   logic                  top, left, right, dec_valid, kept;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         nw[r][0] = win_ff[r][1];
         nw[r][1] = win_ff[r][2];
      end
      nw[0][2] = rd_upper;
      nw[1][2] = rd_middle;
      nw[2][2] = score;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= nw[r][c];
            end
         end
      end
   end

   always_comb begin
      if (x != '0) begin
         cx = x - 1'b1;
         cy = (y >= 12'd1) ? y - 12'd1 : '0;
      end else begin
         cx = XB'(width - 1'b1);
         cy = (y >= 12'd2) ? y - 12'd2 : '0;
      end
      dec_valid = (y >= 12'd2) || ((y == 12'd1) && (x != '0));
      top   = (cy == '0);
      left  = (cx == '0);
      right = (WB'(cx) == width - 1'b1);
      kept  = (nw[1][1] != '0);
      if (suppress_en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if (!(r == 1 && c == 1) && !(r == 0 && top) && !(c == 0 && left)
                   && !(c == 2 && right) && (nw[r][c] >= nw[1][1])) begin
                  kept = 1'b0;
               end
            end
         end
      end
      result = '0;
      if (dec_valid) begin
         result.out_valid = 1'b1;
         result.out_x     = OUT_X_BITS'(cx);
         result.out_y     = (y == ROW_SAT) ? ROW_SAT : cy;
         result.keep      = kept;
      end
   end

endmodule

[src/corner_score_nonmax_suppress_unit.sv]
`timescale 1ns / 1ps
// Top level of the 3x3 corner score non-maximum suppression block.
//
//  channel | dir | handshake                   | payload
//  req     | in  | req_valid / req_stall       | req_data  (req_type)
//  rsp     | out | rsp_valid / rsp_stall       | rsp_data  (rsp_type)
//  csr     | in  | csr_write_en                | csr_index / csr_wdata
//
// One beat per clock while req_stall is low; each beat gives one result beat
// through the line buffer read register, then the result register.
// After reset the line buffers are cleared, with req_stall high until the clear is done.
// A stalled result holds the pipe only once the input stage is also full.
module corner_score_nonmax_suppress_unit
   import csnms_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int SCORE_BITS = DEF_SCORE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int XB = $clog2(MAX_WIDTH);
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int CB = (WB > WIDTH_BITS) ? WB : WIDTH_BITS;

   logic [WIDTH_BITS-1:0] image_width_ff;
   logic                  suppress_en_ff;
   logic [CB-1:0]         width_wide;
   logic [WB-1:0]         width;

   logic                  accept, out_free, s1_adv, lb_busy;
   logic [XB-1:0]         pos_x;
   logic [ROW_BITS-1:0]   pos_y;

   logic                  s1_valid_ff, s1_valid_in;
   logic [XB-1:0]         s1_x_ff;
   logic [ROW_BITS-1:0]   s1_y_ff;
   logic [SCORE_BITS-1:0] s1_score_ff;
   logic [SCORE_BITS-1:0] rd_upper, rd_middle;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, result;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= RST_IMAGE_WIDTH;
         suppress_en_ff <= RST_SUPPRESS_EN;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:     image_width_ff <= csr_wdata[WIDTH_BITS-1:0];
            REG_SUPPRESS_ENABLE: suppress_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_wide = CB'(image_width_ff);
      priority if (width_wide > CB'(MAX_WIDTH)) begin
         width = WB'(MAX_WIDTH);
      end else if (width_wide < CB'(MIN_WIDTH)) begin
         width = WB'(MIN_WIDTH);
      end else begin
         width = WB'(width_wide);
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = lb_busy || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;

   csnms_position #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_data.frame_start),
      .width       (width),
      .x           (pos_x),
      .y           (pos_y)
   );

   csnms_line_buf #(
      .MAX_WIDTH  (MAX_WIDTH),
      .SCORE_BITS (SCORE_BITS)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (pos_x),
      .wr_en     (s1_adv),
      .wr_addr   (s1_x_ff),
      .wr_upper  (rd_middle),
      .wr_middle (s1_score_ff),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle),
      .busy      (lb_busy)
   );

   csnms_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .SCORE_BITS (SCORE_BITS)
   ) u_window (
      .clock       (clock),
      .advance     (s1_adv),
      .x           (s1_x_ff),
      .y           (s1_y_ff),
      .score       (s1_score_ff),
      .rd_upper    (rd_upper),
      .rd_middle   (rd_middle),
      .width       (width),
      .suppress_en (suppress_en_ff),
      .result      (result)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff     <= pos_x;
         s1_y_ff     <= pos_y;
         s1_score_ff <= SCORE_BITS'(req_data.corner_score);
      end
      if (s1_adv) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> lb_busy)
      else $error("line buffer clear not started after reset");

   a_adv_gives_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid)
      else $error("advanced beat did not reach the result register");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid && rsp_stall) |=> (s1_valid_ff && $stable(s1_x_ff)))
      else $error("input stage lost a beat under stall");

   a_no_item_while_clearing: assert property (@(posedge clock) disable iff (reset)
      lb_busy |-> (!s1_valid_ff && !rsp_valid))
      else $error("beat in flight during line buffer clear");

endmodule
